### hw/rtl/pcbn_pkg.sv
// ----------------------------------------------------------------------------
// pcbn_pkg
// shared types and constants of the point cloud box normalizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pcbn_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_OUT       = 30;
    localparam int OUT_BITS       = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ZERO_EXT = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_DIV,
        BK_OUT
    } t_bk_state;

endpackage
`default_nettype wire

### hw/rtl/pcbn_front.sv
// ----------------------------------------------------------------------------
// pcbn_front
// accepts commands, stores points, tracks box, queues read jobs and full-buffer status jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcbn_front import pcbn_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int IW = (COORD_BITS < 32) ? COORD_BITS : 32
) (
    input  wire  logic                 i_clk,
    input  wire  logic                 i_rst_n,
    input  wire  logic                 i_valid,
    output logic                       o_ready,
    input  wire  logic                 i_cmd,
    input  wire  logic [31:0]          i_x,
    input  wire  logic [31:0]          i_y,
    input  wire  logic [31:0]          i_z,
    // job queue
    output logic                       o_job_valid,
    input  wire  logic                 i_job_ready,
    output logic                       o_job_read,
    output logic [AW-1:0]              o_job_idx,
    output logic                       o_job_last,
    output t_status                    o_job_status,
    output logic signed [IW:0]         o_job_sum [3],
    output logic [IW:0]                o_job_ext,
    // store read port
    input  wire  logic [AW-1:0]        i_rd_addr,
    output logic signed [IW-1:0]       o_rd_data [3]
);
    logic signed [IW-1:0] r_mem_x [MAX_POINTS];
    logic signed [IW-1:0] r_mem_y [MAX_POINTS];
    logic signed [IW-1:0] r_mem_z [MAX_POINTS];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rptr;
    logic          r_phase;
    logic signed [IW-1:0] r_min [3];
    logic signed [IW-1:0] r_max [3];
    logic [IW:0]   r_ext;

    logic                 r_q_valid;
    logic                 r_q_read;
    logic [AW-1:0]        r_q_idx;
    logic                 r_q_last;
    t_status              r_q_status;
    logic signed [IW:0]   r_q_sum [3];
    logic [IW:0]          r_q_ext;

    logic signed [IW-1:0] c [3];
    logic [CW-1:0]        cnt_eff;
    logic [CW-1:0]        rp_eff;
    logic signed [IW-1:0] nmin [3];
    logic signed [IW-1:0] nmax [3];
    logic [IW:0]          next_ext;
    logic [IW:0]          e [3];
    logic                 acc;
    logic                 last;

    assign c[0] = i_x[IW-1:0];
    assign c[1] = i_y[IW-1:0];
    assign c[2] = i_z[IW-1:0];

    // a load that restarts the set waits until the queued read has fetched its point
    assign o_ready = !r_q_valid || (i_job_ready && !(r_phase && i_cmd == CMD_LOAD));
    assign acc     = i_valid && o_ready;
    assign cnt_eff = r_phase ? '0 : r_count;
    assign rp_eff  = (r_rptr >= r_count) ? '0 : r_rptr;
    assign last    = (rp_eff + CW'(1)) == r_count;

    always_comb begin
        next_ext = '0;
        for (int a = 0; a < 3; a++) begin
            if (cnt_eff == '0) begin
                nmin[a] = c[a];
                nmax[a] = c[a];
            end else begin
                nmin[a] = (c[a] < r_min[a]) ? c[a] : r_min[a];
                nmax[a] = (c[a] > r_max[a]) ? c[a] : r_max[a];
            end
            e[a] = (IW+1)'({nmax[a][IW-1], nmax[a]} - {nmin[a][IW-1], nmin[a]});
            if (e[a] > next_ext) next_ext = e[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_cmd == CMD_LOAD && cnt_eff < CW'(MAX_POINTS)) begin
            r_mem_x[cnt_eff[AW-1:0]] <= c[0];
            r_mem_y[cnt_eff[AW-1:0]] <= c[1];
            r_mem_z[cnt_eff[AW-1:0]] <= c[2];
        end
        o_rd_data[0] <= r_mem_x[i_rd_addr];
        o_rd_data[1] <= r_mem_y[i_rd_addr];
        o_rd_data[2] <= r_mem_z[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rptr    <= '0;
            r_phase   <= 1'b0;
            r_ext     <= '0;
            r_q_valid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= '0;
                r_max[a] <= '0;
            end
        end else begin
            if (r_q_valid && i_job_ready) r_q_valid <= 1'b0;
            if (acc) begin
                if (i_cmd == CMD_LOAD) begin
                    if (r_phase) begin
                        r_phase <= 1'b0;
                        r_rptr  <= '0;
                        r_count <= '0;
                    end
                    if (cnt_eff >= CW'(MAX_POINTS)) begin
                        r_q_valid  <= 1'b1;
                        r_q_read   <= 1'b0;
                        r_q_status <= ST_FULL;
                        r_q_last   <= 1'b0;
                    end else begin
                        r_count <= cnt_eff + CW'(1);
                        r_ext   <= next_ext;
                        for (int a = 0; a < 3; a++) begin
                            r_min[a] <= nmin[a];
                            r_max[a] <= nmax[a];
                        end
                    end
                end else if (r_count == '0) begin
                    r_q_valid  <= 1'b1;
                    r_q_read   <= 1'b0;
                    r_q_status <= ST_EMPTY;
                    r_q_last   <= 1'b0;
                end else begin
                    r_phase    <= 1'b1;
                    r_q_valid  <= 1'b1;
                    r_q_read   <= (r_ext != '0);
                    r_q_status <= (r_ext == '0) ? ST_ZERO_EXT : ST_OK;
                    r_q_last   <= last;
                    r_q_idx    <= rp_eff[AW-1:0];
                    r_q_ext    <= r_ext;
                    for (int a = 0; a < 3; a++)
                        r_q_sum[a] <= (IW+1)'({r_min[a][IW-1], r_min[a]}
                                              + {r_max[a][IW-1], r_max[a]});
                    r_rptr <= last ? '0 : rp_eff + CW'(1);
                end
            end
        end
    end

    assign o_job_valid  = r_q_valid;
    assign o_job_read   = r_q_read;
    assign o_job_idx    = r_q_idx;
    assign o_job_last   = r_q_last;
    assign o_job_status = r_q_status;
    assign o_job_sum    = r_q_sum;
    assign o_job_ext    = r_q_ext;
endmodule
`default_nettype wire

### hw/rtl/pcbn_back.sv
// ----------------------------------------------------------------------------
// pcbn_back
// fetches a stored point and divides its three axes with one shared divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcbn_back import pcbn_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int IW = (COORD_BITS < 32) ? COORD_BITS : 32
) (
    input  wire  logic                 i_clk,
    input  wire  logic                 i_rst_n,
    input  wire  logic                 i_job_valid,
    output logic                       o_job_ready,
    input  wire  logic                 i_job_read,
    input  wire  logic [AW-1:0]        i_job_idx,
    input  wire  logic                 i_job_last,
    input  wire  t_status              i_job_status,
    input  wire  logic signed [IW:0]   i_job_sum [3],
    input  wire  logic [IW:0]          i_job_ext,
    output logic [AW-1:0]              o_rd_addr,
    input  wire  logic signed [IW-1:0] i_rd_data [3],
    output logic                       o_valid,
    input  wire  logic                 i_ready,
    output logic [OUT_BITS-1:0]        o_norm [3],
    output logic                       o_last,
    output t_status                    o_status
);
    localparam int NW = IW + 2;
    localparam int SW = $clog2(FRAC_OUT + 1);

    t_bk_state r_state, n_state;
    logic [1:0]            r_axis;
    logic [SW-1:0]         r_step;
    logic [NW:0]           r_rem;
    logic [NW:0]           r_den;
    logic [FRAC_OUT-1:0]   r_q;
    logic [2:0]            r_neg;
    logic signed [NW-1:0]  r_num [3];
    logic signed [IW:0]    r_sum [3];
    logic [AW-1:0]         r_idx;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_norm [3];
    logic                  r_last;
    t_status               r_status;

    logic                  take;
    logic                  out_free;
    logic [NW:0]           sh;
    logic [NW-1:0]         mag;

    assign out_free    = !r_out_valid || i_ready;
    assign o_job_ready = (r_state == BK_IDLE) && out_free;
    assign take        = i_job_valid && o_job_ready;
    assign o_rd_addr   = take ? i_job_idx : r_idx;
    assign sh          = {r_rem[NW-1:0], 1'b0};
    assign mag         = r_num[r_axis][NW-1] ? NW'(-r_num[r_axis]) : NW'(r_num[r_axis]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (take && i_job_read) n_state = BK_FETCH;
            BK_FETCH: n_state = BK_DIV;
            BK_DIV:   if (r_step == SW'(FRAC_OUT) && r_axis == 2'd2) n_state = BK_OUT;
            BK_OUT:   if (out_free) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            if (take && !i_job_read) r_out_valid <= 1'b1;
            if (r_state == BK_OUT && out_free) r_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_idx    <= i_job_idx;
            r_last   <= i_job_last;
            r_status <= i_job_status;
            r_sum    <= i_job_sum;
            r_den    <= (NW+1)'({i_job_ext, 1'b0});
            if (!i_job_read) begin
                for (int a = 0; a < 3; a++) r_norm[a] <= '0;
            end
        end
        unique case (r_state)
            BK_FETCH: begin
                for (int a = 0; a < 3; a++)
                    r_num[a] <= NW'($signed({i_rd_data[a], 1'b0})) - NW'(r_sum[a]);
                r_axis <= 2'd0;
                r_step <= '0;
            end
            BK_DIV: begin
                if (r_step == '0) begin
                    r_rem <= (NW+1)'(mag);
                    r_q   <= '0;
                    r_neg[r_axis] <= r_num[r_axis][NW-1];
                    r_step <= r_step + SW'(1);
                end else begin
                    if (sh >= r_den) begin
                        r_rem <= sh - r_den;
                        r_q   <= {r_q[FRAC_OUT-2:0], 1'b1};
                    end else begin
                        r_rem <= sh;
                        r_q   <= {r_q[FRAC_OUT-2:0], 1'b0};
                    end
                    if (r_step == SW'(FRAC_OUT)) begin
                        r_step <= '0;
                        r_axis <= r_axis + 2'd1;
                    end else begin
                        r_step <= r_step + SW'(1);
                    end
                end
                if (r_step != '0 && r_step == SW'(FRAC_OUT)) begin
                    if (sh >= r_den)
                        r_norm[r_axis] <= r_neg[r_axis] ?
                            OUT_BITS'(-{2'b0, r_q[FRAC_OUT-2:0], 1'b1}) :
                            OUT_BITS'({2'b0, r_q[FRAC_OUT-2:0], 1'b1});
                    else
                        r_norm[r_axis] <= r_neg[r_axis] ?
                            OUT_BITS'(-{2'b0, r_q[FRAC_OUT-2:0], 1'b0}) :
                            OUT_BITS'({2'b0, r_q[FRAC_OUT-2:0], 1'b0});
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_norm   = r_norm;
    assign o_last   = r_last;
    assign o_status = r_status;
endmodule
`default_nettype wire

### hw/rtl/point_cloud_box_normalizer.sv
// ----------------------------------------------------------------------------
// point_cloud_box_normalizer
// bounding box normalization of a stored 3d point set
// ----------------------------------------------------------------------------
// s_axis carries commands: tuser is cmd (0 load, 1 read), tdata holds x, y, z
// in signed q16.16. loads store the point and widen the box, and give no beat
// unless the buffer is full. reads give one m_axis beat: normalized x, y, z in
// signed q2.30, tlast on the final stored point, tuser status.
// a load or a status-only read is registered in the job queue and then in the
// back end output register, which drives its beat. in the back end a
// normalizing read does a store read, then each axis on the shared radix-2 divider.
// a short job queue lets the front take the next command while the back end
// divides; a stalled output holds the back end, then the queue, then s_axis.
// a load that starts a new set after readout waits while a job is queued.
// reset empties the set and the queue; stored points are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_box_normalizer import pcbn_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire  logic         i_clk,
    input  wire  logic         i_rst_n,
    input  wire  logic         s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  logic [95:0]  s_axis_tdata,  // x_coord, y_coord, z_coord
    input  wire  logic         s_axis_tuser,  // cmd
    output logic               m_axis_tvalid,
    input  wire  logic         m_axis_tready,
    output logic [95:0]        m_axis_tdata,  // norm_x, norm_y, norm_z
    output logic               m_axis_tlast,  // last_point
    output logic [1:0]         m_axis_tuser   // status
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int IW = (COORD_BITS < 32) ? COORD_BITS : 32;

    logic                 job_valid, job_ready, job_read, job_last;
    logic [AW-1:0]        job_idx, rd_addr;
    t_status              job_status, out_status;
    logic signed [IW:0]   job_sum [3];
    logic [IW:0]          job_ext;
    logic signed [IW-1:0] rd_data [3];
    logic [OUT_BITS-1:0]  norm [3];

    pcbn_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tuser),
        .i_x(s_axis_tdata[31:0]), .i_y(s_axis_tdata[63:32]), .i_z(s_axis_tdata[95:64]),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job_read(job_read),
        .o_job_idx(job_idx), .o_job_last(job_last), .o_job_status(job_status),
        .o_job_sum(job_sum), .o_job_ext(job_ext),
        .i_rd_addr(rd_addr), .o_rd_data(rd_data)
    );

    pcbn_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job_read(job_read),
        .i_job_idx(job_idx), .i_job_last(job_last), .i_job_status(job_status),
        .i_job_sum(job_sum), .i_job_ext(job_ext),
        .o_rd_addr(rd_addr), .i_rd_data(rd_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_norm(norm), .o_last(m_axis_tlast), .o_status(out_status)
    );

    assign m_axis_tdata = {norm[2], norm[1], norm[0]};
    assign m_axis_tuser = out_status;
endmodule
`default_nettype wire
